[rtl/core/npc_pkg.sv]
// Package with the payload types and constants of the near-plane triangle clipper.
`timescale 1ns / 1ps

package npc_pkg;

  // Width of one clip-space coordinate.
  localparam int COORD_WIDTH = 32;
  // Default number of fraction bits of the crossing fraction.
  localparam int T_FRAC_BITS_DEF = 16;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One vertex as four coordinates: index 0 is x, 1 is y, 2 is z and 3 is w.
  typedef logic [3:0][COORD_WIDTH-1:0] vtx_t;

  // One input triangle.
  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v0_w;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v1_w;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v2_w;
  } tri_in_t;

  // One emitted vertex.
  typedef struct packed {
    coord_t     out_x;
    coord_t     out_y;
    coord_t     out_z;
    coord_t     out_w;
    logic [1:0] corner;
    logic       tri_index;
    logic       last;
  } res_t;

  // How many vertices of a triangle lie inside the near plane.
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_TWO  = 2'd2,
    CLS_ALL  = 2'd3
  } clip_cls_e;

endpackage

[rtl/core/near_plane_triangle_clipper_top.sv]
// Near-plane triangle clipper: pipelined clip of one triangle against z >= -w.
//
// Input channel: a triangle transfer takes place at a rising clock edge where
// start is high and busy is low. The triangle enters the pipeline at once.
// Result channel: every emitted vertex is shown on res_o for one cycle with
// res_valid_o high; the receiver takes it at the edge that ends that cycle.
// A clipped triangle yields 0, 3 or 6 vertices, back to back, and the last
// one carries res_o.last.
// Path of a triangle: input register, classification register, divider set-up
// register, divider stages, multiplier register, then the output slot registers.
// The output port sends one vertex per cycle; a triangle yields 3 vertices
// (6 when clipped into two, none when it lies fully outside; a fully
// outside triangle still uses one pipeline slot). busy rises while the output
// sequencer is still sending a triangle and the pipeline holds.
// The crossing fractions come from two restoring dividers cut into stages of
// two quotient bits each; the interpolation uses eight multipliers in one stage.
// Reset clears all valid bits and the output sequencer; nothing is in flight.
`timescale 1ns / 1ps

module near_plane_triangle_clipper_top import npc_pkg::*; #(
  parameter int T_FRAC_BITS = npc_pkg::T_FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  tri_in_t tri_i,
  output logic    res_valid_o,
  output res_t    res_o
);

  localparam int CW      = COORD_WIDTH;
  localparam int DW      = CW + 1;
  localparam int RW      = CW + 2;
  localparam int PW      = T_FRAC_BITS + CW + 2;
  localparam int DIV_STG = (T_FRAC_BITS + 1) / 2;

  localparam logic [2:0] K_LAST3 = 3'd2;
  localparam logic [2:0] K_LAST6 = 3'd5;

  typedef logic [3:0][DW-1:0] diff_t;

  typedef struct packed {
    clip_cls_e              cls;
    vtx_t                   a1;
    vtx_t                   b1;
    vtx_t                   a2;
    diff_t                  d1;
    diff_t                  d2;
    logic [RW-1:0]          rem1;
    logic [RW-1:0]          rem2;
    logic [DW-1:0]          den1;
    logic [DW-1:0]          den2;
    logic [T_FRAC_BITS-1:0] q1;
    logic [T_FRAC_BITS-1:0] q2;
  } div_t;

  logic adv;
  logic accept;

  logic    st0_vld_q;
  tri_in_t st0_q;

  logic      st1_vld_q;
  clip_cls_e st1_cls_q, st1_cls_d;
  vtx_t      st1_a1_q, st1_b1_q, st1_a2_q, st1_b2_q;
  vtx_t      st1_a1_d, st1_b1_d, st1_a2_d, st1_b2_d;

  logic [DIV_STG:0] div_vld_q;
  div_t             div_q [DIV_STG+1];
  div_t             div0_d;

  logic                    mul_vld_q;
  clip_cls_e               mul_cls_q;
  vtx_t                    mul_a1_q, mul_b1_q, mul_a2_q;
  logic [3:0][PW-1:0]      mul_p1_q, mul_p2_q;
  logic [3:0][PW-1:0]      mul_p1_d, mul_p2_d;

  logic       act_q, act_d;
  logic       six_q, six_d;
  logic [2:0] k_q, k_d;
  vtx_t       slot_a_q, slot_b_q, slot_c_q, slot_d_q;
  vtx_t       slot_a_d, slot_b_d, slot_c_d, slot_d_d;
  vtx_t       out_v;

  // The whole pipeline moves when the sequencer is free or sends its last vertex.
  assign adv    = !act_q || (k_q == (six_q ? K_LAST6 : K_LAST3));
  assign busy   = !adv;
  assign accept = start && !busy;

  // Classify the vertices and pick the edges that cross the plane.
  always_comb begin
    vtx_t              v0, v1, v2;
    logic [2:0]        ins;
    logic signed [CW:0] s0, s1, s2;
    v0 = {st0_q.v0_w, st0_q.v0_z, st0_q.v0_y, st0_q.v0_x};
    v1 = {st0_q.v1_w, st0_q.v1_z, st0_q.v1_y, st0_q.v1_x};
    v2 = {st0_q.v2_w, st0_q.v2_z, st0_q.v2_y, st0_q.v2_x};
    s0 = {v0[2][CW-1], v0[2]} + {v0[3][CW-1], v0[3]};
    s1 = {v1[2][CW-1], v1[2]} + {v1[3][CW-1], v1[3]};
    s2 = {v2[2][CW-1], v2[2]} + {v2[3][CW-1], v2[3]};
    ins = {~s2[CW], ~s1[CW], ~s0[CW]};
    st1_cls_d = CLS_NONE;
    st1_a1_d  = v0;
    st1_b1_d  = v2;
    st1_a2_d  = v1;
    st1_b2_d  = v2;
    case (ins)
      3'b111: begin
        st1_cls_d = CLS_ALL;
      end
      3'b001: begin
        st1_cls_d = CLS_ONE;
        st1_a1_d = v0; st1_b1_d = v1; st1_a2_d = v0; st1_b2_d = v2;
      end
      3'b010: begin
        st1_cls_d = CLS_ONE;
        st1_a1_d = v1; st1_b1_d = v2; st1_a2_d = v1; st1_b2_d = v0;
      end
      3'b100: begin
        st1_cls_d = CLS_ONE;
        st1_a1_d = v2; st1_b1_d = v0; st1_a2_d = v2; st1_b2_d = v1;
      end
      3'b011: begin
        st1_cls_d = CLS_TWO;
        st1_a1_d = v0; st1_b1_d = v2; st1_a2_d = v1; st1_b2_d = v2;
      end
      3'b101: begin
        st1_cls_d = CLS_TWO;
        st1_a1_d = v2; st1_b1_d = v1; st1_a2_d = v0; st1_b2_d = v1;
      end
      3'b110: begin
        st1_cls_d = CLS_TWO;
        st1_a1_d = v1; st1_b1_d = v0; st1_a2_d = v2; st1_b2_d = v0;
      end
      default: begin
        st1_cls_d = CLS_NONE;
      end
    endcase
  end

  // Set up both divisions and the edge differences.
  always_comb begin
    logic [DW-1:0] da1, db1, da2, db2;
    da1 = {st1_a1_q[2][CW-1], st1_a1_q[2]} + {st1_a1_q[3][CW-1], st1_a1_q[3]};
    db1 = {st1_b1_q[2][CW-1], st1_b1_q[2]} + {st1_b1_q[3][CW-1], st1_b1_q[3]};
    da2 = {st1_a2_q[2][CW-1], st1_a2_q[2]} + {st1_a2_q[3][CW-1], st1_a2_q[3]};
    db2 = {st1_b2_q[2][CW-1], st1_b2_q[2]} + {st1_b2_q[3][CW-1], st1_b2_q[3]};
    div0_d.cls  = st1_cls_q;
    div0_d.a1   = st1_a1_q;
    div0_d.b1   = st1_b1_q;
    div0_d.a2   = st1_a2_q;
    div0_d.rem1 = {1'b0, da1};
    div0_d.rem2 = {1'b0, da2};
    div0_d.den1 = da1 - db1;
    div0_d.den2 = da2 - db2;
    div0_d.q1   = '0;
    div0_d.q2   = '0;
    for (int c = 0; c < 4; c++) begin
      div0_d.d1[c] = {st1_b1_q[c][CW-1], st1_b1_q[c]} - {st1_a1_q[c][CW-1], st1_a1_q[c]};
      div0_d.d2[c] = {st1_b2_q[c][CW-1], st1_b2_q[c]} - {st1_a2_q[c][CW-1], st1_a2_q[c]};
    end
  end

  // Front registers and the valid bits of the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st0_vld_q <= 1'b0;
      st1_vld_q <= 1'b0;
      div_vld_q <= '0;
    end else if (adv) begin
      st0_vld_q <= accept;
      st1_vld_q <= st0_vld_q;
      div_vld_q <= {div_vld_q[DIV_STG-1:0], st1_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st0_q <= tri_i;
    end
    if (adv) begin
      st1_cls_q <= st1_cls_d;
      st1_a1_q  <= st1_a1_d;
      st1_b1_q  <= st1_b1_d;
      st1_a2_q  <= st1_a2_d;
      st1_b2_q  <= st1_b2_d;
      div_q[0]  <= div0_d;
    end
  end

  // Restoring division stages, two quotient bits per stage.
  for (genvar g = 0; g < DIV_STG; g++) begin : g_div
    div_t step_d;

    always_comb begin
      step_d = div_q[g];
      for (int s = 0; s < 2; s++) begin
        if (g * 2 + s < T_FRAC_BITS) begin
          step_d.rem1 = {step_d.rem1[RW-2:0], 1'b0};
          if (step_d.rem1 >= {1'b0, step_d.den1}) begin
            step_d.rem1 = step_d.rem1 - {1'b0, step_d.den1};
            step_d.q1   = {step_d.q1[T_FRAC_BITS-2:0], 1'b1};
          end else begin
            step_d.q1   = {step_d.q1[T_FRAC_BITS-2:0], 1'b0};
          end
          step_d.rem2 = {step_d.rem2[RW-2:0], 1'b0};
          if (step_d.rem2 >= {1'b0, step_d.den2}) begin
            step_d.rem2 = step_d.rem2 - {1'b0, step_d.den2};
            step_d.q2   = {step_d.q2[T_FRAC_BITS-2:0], 1'b1};
          end else begin
            step_d.q2   = {step_d.q2[T_FRAC_BITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[g+1] <= step_d;
      end
    end
  end

  // Scale each edge difference by its crossing fraction.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mul_p1_d[c] = PW'($signed({1'b0, div_q[DIV_STG].q1}))
                  * PW'($signed(div_q[DIV_STG].d1[c]));
      mul_p2_d[c] = PW'($signed({1'b0, div_q[DIV_STG].q2}))
                  * PW'($signed(div_q[DIV_STG].d2[c]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else if (adv) begin
      mul_vld_q <= div_vld_q[DIV_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_cls_q <= div_q[DIV_STG].cls;
      mul_a1_q  <= div_q[DIV_STG].a1;
      mul_b1_q  <= div_q[DIV_STG].b1;
      mul_a2_q  <= div_q[DIV_STG].a2;
      mul_p1_q  <= mul_p1_d;
      mul_p2_q  <= mul_p2_d;
    end
  end

  // Form the crossing points and arrange the vertex slots of the sequencer.
  always_comb begin
    vtx_t            p1, p2;
    logic [PW-1:0]   sh1, sh2;
    for (int c = 0; c < 4; c++) begin
      sh1   = $signed(mul_p1_q[c]) >>> T_FRAC_BITS;
      sh2   = $signed(mul_p2_q[c]) >>> T_FRAC_BITS;
      p1[c] = mul_a1_q[c] + sh1[CW-1:0];
      p2[c] = mul_a2_q[c] + sh2[CW-1:0];
    end
    slot_a_d = mul_a1_q;
    slot_d_d = p2;
    case (mul_cls_q)
      CLS_ALL: begin
        slot_b_d = mul_a2_q;
        slot_c_d = mul_b1_q;
      end
      CLS_ONE: begin
        slot_b_d = p1;
        slot_c_d = p2;
      end
      default: begin
        slot_b_d = mul_a2_q;
        slot_c_d = p1;
      end
    endcase
  end

  // Output sequencer: walks three or six vertices, one per cycle.
  always_comb begin
    act_d = act_q;
    six_d = six_q;
    k_d   = k_q;
    if (adv) begin
      act_d = mul_vld_q && (mul_cls_q != CLS_NONE);
      six_d = (mul_cls_q == CLS_TWO);
      k_d   = '0;
    end else begin
      k_d = k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      six_q <= 1'b0;
      k_q   <= '0;
    end else begin
      act_q <= act_d;
      six_q <= six_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slot_a_q <= slot_a_d;
      slot_b_q <= slot_b_d;
      slot_c_q <= slot_c_d;
      slot_d_q <= slot_d_d;
    end
  end

  // Result port.
  always_comb begin
    case (k_q)
      3'd0:    out_v = slot_a_q;
      3'd1:    out_v = slot_b_q;
      3'd2:    out_v = slot_c_q;
      3'd3:    out_v = slot_b_q;
      3'd4:    out_v = slot_d_q;
      3'd5:    out_v = slot_c_q;
      default: out_v = slot_a_q;
    endcase
  end

  assign res_valid_o     = act_q;
  assign res_o.out_x     = out_v[0];
  assign res_o.out_y     = out_v[1];
  assign res_o.out_z     = out_v[2];
  assign res_o.out_w     = out_v[3];
  assign res_o.corner    = (k_q >= 3'd3) ? 2'(k_q - 3'd3) : k_q[1:0];
  assign res_o.tri_index = (k_q >= 3'd3);
  assign res_o.last      = (k_q == (six_q ? K_LAST6 : K_LAST3));

  // The vertices of one input triangle leave without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o)
    else $error("result stream broke inside a triangle");

  // A second output triangle only comes from a two-inside clip.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.tri_index |-> six_q)
    else $error("second triangle without a two-inside clip");

  // While the pipeline holds, the last divider stage keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(div_q[DIV_STG]) && $stable(div_vld_q))
    else $error("pipeline moved during a hold");

  // An accepted triangle always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> st0_vld_q)
    else $error("accepted triangle was lost");

endmodule
